### hdl/rbd_pkg.sv
// ============================================================================
// rbd_pkg
// Shared command codes, status codes and response types of the ring buffer
// deque.
// ============================================================================
package rbd_pkg;

    localparam int unsigned VALUE_WIDTH = 32;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_POP_FRONT  = 2'd1,
        MODE_PUSH_BACK  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Response bookkeeping carried from the control unit to the output side.
    typedef struct packed {
        logic    strobe;
        logic    pop_ok;
        t_status status;
    } t_rsp;

endpackage

### hdl/ring_buffer_deque.sv
// ============================================================================
// ring_buffer_deque
// Double-ended queue in a circular single-port store with front, back and
// occupancy tracking.
// ============================================================================
// Usage:
//   Raise start with i_mode and i_push_value; the request is taken at the
//   rising edge where start is high and busy is low. i_mode selects push
//   front, pop front, push back or pop back; pops ignore i_push_value.
//   Exactly one response follows each request, in the cycle after it is taken:
//   o_strobe is high for that single cycle with o_pop_value, o_status and
//   o_occupancy. The receiver cannot stall; it must capture on the strobe.
//   No new request is taken in the response cycle: busy is high then, while
//   the single-port store returns the popped word through its registered read.
//   A push on a full store is dropped with status 2; a pop on an empty store
//   returns zero with status 1; the state is unchanged in both cases.
//   Words are stored at WORD_WIDTH bits and sign-extended back to 32 bits.
//   Synchronous reset empties the queue at once (pointers and count clear);
//   the store itself is not cleared and needs no clearing pass.
// ============================================================================
module ring_buffer_deque
    import rbd_pkg::*;
#(
    parameter int unsigned DEPTH      = 1024,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_mode,
    input  logic signed [31:0]         i_push_value,
    output logic                       o_strobe,
    output logic signed [31:0]         o_pop_value,
    output logic [1:0]                 o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_occupancy
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic [WORD_WIDTH-1:0] mem_rdata;
    logic [63:0]           push_wide;
    logic signed [63:0]    pop_wide;
    t_rsp                  rsp;

    // Drop the push word to the stored width.
    assign push_wide = 64'($unsigned(i_push_value));
    assign mem_wdata = push_wide[WORD_WIDTH-1:0];

    rbd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .busy    (busy),
        .o_we    (mem_we),
        .o_addr  (mem_addr),
        .o_count (o_occupancy),
        .o_rsp   (rsp)
    );

    rbd_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Sign-extend the stored word, then keep the 32-bit field.
    assign pop_wide = 64'(signed'(mem_rdata));

    assign o_strobe    = rsp.strobe;
    assign o_status    = rsp.status;
    assign o_pop_value = rsp.pop_ok ? signed'(pop_wide[VALUE_WIDTH-1:0]) : '0;

endmodule

### hdl/rbd_ram.sv
// ============================================================================
// rbd_ram
// Single-port synchronous RAM with a registered read.
// ============================================================================
module rbd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rbd_ctrl.sv
// ============================================================================
// rbd_ctrl
// Pointer and occupancy control: decodes a request, checks full and empty,
// drives the store address and write enable, and tracks the response.
// ============================================================================
module rbd_ctrl
    import rbd_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [1:0]                 i_mode,
    output logic                       busy,
    output logic                       o_we,
    output logic [$clog2(DEPTH)-1:0]   o_addr,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output t_rsp                       o_rsp
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_front;
    logic [AW-1:0] n_front;
    logic [AW-1:0] r_back;
    logic [AW-1:0] n_back;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_busy;
    t_rsp          r_rsp;
    t_rsp          n_rsp;

    logic          accept;
    logic          full;
    logic          empty;
    logic          re;
    logic [AW-1:0] front_up;
    logic [AW-1:0] front_dn;
    logic [AW-1:0] back_up;
    logic [AW-1:0] back_dn;

    assign accept = start && !r_busy;
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);

    // Wrap both pointers modulo DEPTH.
    assign front_up = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign front_dn = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign back_up  = (r_back == AW'(DEPTH - 1)) ? '0 : r_back + AW'(1);
    assign back_dn  = (r_back == '0) ? AW'(DEPTH - 1) : r_back - AW'(1);

    always_comb begin
        n_front      = r_front;
        n_back       = r_back;
        n_count      = r_count;
        o_we         = 1'b0;
        re           = 1'b0;
        o_addr       = r_front;
        n_rsp.strobe = accept;
        n_rsp.pop_ok = 1'b0;
        n_rsp.status = STATUS_OK;
        if (accept) begin
            unique case (t_mode'(i_mode))
                MODE_PUSH_FRONT: begin
                    if (full) begin
                        n_rsp.status = STATUS_FULL;
                    end else begin
                        o_we    = 1'b1;
                        o_addr  = front_dn;
                        n_front = front_dn;
                        n_count = r_count + CW'(1);
                    end
                end
                MODE_POP_FRONT: begin
                    if (empty) begin
                        n_rsp.status = STATUS_EMPTY;
                    end else begin
                        re      = 1'b1;
                        o_addr  = r_front;
                        n_front = front_up;
                        n_count = r_count - CW'(1);
                    end
                end
                MODE_PUSH_BACK: begin
                    if (full) begin
                        n_rsp.status = STATUS_FULL;
                    end else begin
                        o_we    = 1'b1;
                        o_addr  = r_back;
                        n_back  = back_up;
                        n_count = r_count + CW'(1);
                    end
                end
                MODE_POP_BACK: begin
                    if (empty) begin
                        n_rsp.status = STATUS_EMPTY;
                    end else begin
                        re      = 1'b1;
                        o_addr  = back_dn;
                        n_back  = back_dn;
                        n_count = r_count - CW'(1);
                    end
                end
            endcase
        end
        n_rsp.pop_ok = re;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_busy  <= 1'b0;
            r_rsp   <= '{strobe: 1'b0, pop_ok: 1'b0, status: STATUS_OK};
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_busy  <= accept;
            r_rsp   <= n_rsp;
        end
    end

    assign busy    = r_busy;
    assign o_count = r_count;
    assign o_rsp   = r_rsp;

    // Occupancy stays within the store.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy exceeds depth");

    // Hold all pointer state while no request is taken.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !accept) |=>
            (r_count == $past(r_count) && r_front == $past(r_front)
             && r_back == $past(r_back)))
        else $error("state moved without a request");

    // Every accepted request yields exactly one strobe in the next cycle.
    a_one_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept) |=> (r_rsp.strobe && r_busy))
        else $error("accepted request produced no response");

    // A successful pop always takes one entry away.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && re) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not decrement occupancy");

endmodule

### verif/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for ring_buffer_deque. A short table of requests covers
// the empty and data extremes, then random requests fill the queue past full
// and drain part of it again. Every response is checked field by field against
// its typed table row or a shadow deque kept in step with each accepted request.
// ============================================================================
module testbench;
    import rbd_pkg::*;

    localparam int unsigned DEPTH      = 1024;
    localparam int unsigned WORD_WIDTH = 32;
    localparam int unsigned OCC_W      = $clog2(DEPTH + 1);
    localparam int unsigned PTR_W      = $clog2(DEPTH);
    localparam int          N_DIRECTED = 16;

    // One response as the block should present it on the strobe.
    typedef struct packed {
        logic signed [31:0] pop_value;
        t_status            status;
        logic [OCC_W-1:0]   occupancy;
    } t_response;

    // One row of the directed table. Rows with typed set carry a response
    // read straight off the spec; the rest take the shadow deque's answer.
    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] value;
        logic               typed;
        t_response          want;
    } t_step;

    localparam t_step DIRECTED_STEPS [N_DIRECTED] = '{
        // Pops on the empty queue after reset
        '{MODE_POP_FRONT,  32'sh00000000, 1'b1, '{32'sh00000000, STATUS_EMPTY, 11'd0}},
        '{MODE_POP_BACK,   32'sh00000000, 1'b1, '{32'sh00000000, STATUS_EMPTY, 11'd0}},
        // Most positive and most negative words, one at each end
        '{MODE_PUSH_BACK,  32'sh7FFFFFFF, 1'b1, '{32'sh00000000, STATUS_OK,    11'd1}},
        '{MODE_PUSH_FRONT, 32'sh80000000, 1'b1, '{32'sh00000000, STATUS_OK,    11'd2}},
        '{MODE_POP_FRONT,  32'sh00000000, 1'b1, '{32'sh80000000, STATUS_OK,    11'd1}},
        '{MODE_POP_BACK,   32'sh00000000, 1'b1, '{32'sh7FFFFFFF, STATUS_OK,    11'd0}},
        '{MODE_POP_BACK,   32'sh00000000, 1'b1, '{32'sh00000000, STATUS_EMPTY, 11'd0}},
        // All ones and all zeros, both pushed at the front
        '{MODE_PUSH_FRONT, 32'shFFFFFFFF, 1'b1, '{32'sh00000000, STATUS_OK,    11'd1}},
        '{MODE_PUSH_FRONT, 32'sh00000000, 1'b1, '{32'sh00000000, STATUS_OK,    11'd2}},
        // Alternating patterns at the back, then drain from mixed ends
        '{MODE_PUSH_BACK,  32'sh5A5AA5A5, 1'b0, '0},
        '{MODE_PUSH_BACK,  32'shA5A55A5A, 1'b0, '0},
        '{MODE_POP_BACK,   32'sh00000000, 1'b0, '0},
        '{MODE_POP_FRONT,  32'sh00000000, 1'b0, '0},
        '{MODE_POP_FRONT,  32'sh00000000, 1'b0, '0},
        '{MODE_POP_BACK,   32'sh00000000, 1'b0, '0},
        // A pop must ignore whatever sits on the push value port
        '{MODE_POP_FRONT,  32'sh12345678, 1'b1, '{32'sh00000000, STATUS_EMPTY, 11'd0}}
    };

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     start        = 1'b0;
    logic [1:0]               i_mode       = '0;
    logic signed [31:0]       i_push_value = '0;
    logic                     busy;
    logic                     o_strobe;
    logic signed [31:0]       o_pop_value;
    logic [1:0]               o_status;
    logic [OCC_W-1:0]         o_occupancy;

    // Shadow deque: the contents and pointers the block should hold.
    logic [WORD_WIDTH-1:0]    shadow_store [DEPTH];
    logic [PTR_W-1:0]         shadow_front = '0;
    logic [PTR_W-1:0]         shadow_back  = '0;
    logic [OCC_W-1:0]         shadow_count = '0;

    t_response                due_responses [$];

    int                       sent_requests = 0;
    int                       full_drops    = 0;
    int                       empty_pops    = 0;
    int                       peak_count    = 0;
    int                       errors        = 0;
    int                       calm_left     = 0;

    ring_buffer_deque #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_strobe     (o_strobe),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [PTR_W-1:0] ptr_up(logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_down(logic [PTR_W-1:0] ptr);
        return (ptr == '0) ? PTR_W'(DEPTH - 1) : ptr - PTR_W'(1);
    endfunction

    // Apply one request to the shadow deque and return the response it causes.
    function automatic t_response shadow_apply(t_mode mode, logic signed [31:0] value);
        t_response                    rsp;
        logic signed [WORD_WIDTH-1:0] word;
        rsp.pop_value = '0;
        rsp.status    = STATUS_OK;
        if (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK) begin
            if (shadow_count == OCC_W'(DEPTH)) begin
                // Drop the word; nothing moves
                rsp.status = STATUS_FULL;
                full_drops++;
            end else if (mode == MODE_PUSH_FRONT) begin
                shadow_front               = ptr_down(shadow_front);
                shadow_store[shadow_front] = value[WORD_WIDTH-1:0];
                shadow_count++;
            end else begin
                shadow_store[shadow_back] = value[WORD_WIDTH-1:0];
                shadow_back               = ptr_up(shadow_back);
                shadow_count++;
            end
        end else begin
            if (shadow_count == '0) begin
                rsp.status = STATUS_EMPTY;
                empty_pops++;
            end else if (mode == MODE_POP_FRONT) begin
                word          = shadow_store[shadow_front];
                rsp.pop_value = word;
                shadow_front  = ptr_up(shadow_front);
                shadow_count--;
            end else begin
                shadow_back   = ptr_down(shadow_back);
                word          = shadow_store[shadow_back];
                rsp.pop_value = word;
                shadow_count--;
            end
        end
        rsp.occupancy = shadow_count;
        if (int'(shadow_count) > peak_count) peak_count = int'(shadow_count);
        return rsp;
    endfunction

    // Idle gap before a request: mostly random, with calm stretches of
    // back-to-back requests mixed in.
    function automatic int pick_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 18);
    endfunction

    // Random word, with the sign and zero extremes showing up often.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh80000000;
            1:       return 32'sh7FFFFFFF;
            2:       return 32'sh00000000;
            3:       return 32'shFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // Push with the given chance in percent, else pop; either end at random.
    function automatic t_mode pick_mode(int push_pct);
        logic at_back;
        at_back = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < push_pct)
            return at_back ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        return at_back ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    // Issue one request and hold it until the block takes it. Start stays
    // high when the next request follows with no gap.
    task automatic send_request(input t_mode mode, input logic signed [31:0] value,
                                input int gap, input logic typed, input t_response want);
        t_response rsp;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_push_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // Taken at this edge: advance the shadow deque and queue the answer
        rsp = shadow_apply(mode, value);
        if (typed) rsp = want;
        due_responses.push_back(rsp);
        sent_requests++;
    endtask

    // Check every strobed response against the oldest outstanding request.
    always @(posedge i_clk) begin : check_responses
        t_response want;
        if (i_rst_n && o_strobe) begin
            if (due_responses.size() == 0) begin
                $display("%0t: unexpected response, pop_value %0d status %0d occupancy %0d",
                         $time, o_pop_value, o_status, o_occupancy);
                errors++;
            end else begin
                want = due_responses.pop_front();
                if (o_pop_value !== want.pop_value) begin
                    $display("%0t: pop_value expected %0d actual %0d",
                             $time, want.pop_value, o_pop_value);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, o_occupancy);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty pops, data extremes, every mode
        for (int row = 0; row < N_DIRECTED; row++) begin
            send_request(DIRECTED_STEPS[row].mode, DIRECTED_STEPS[row].value, pick_gap(),
                         DIRECTED_STEPS[row].typed, DIRECTED_STEPS[row].want);
        end

        // Balanced traffic near empty: pops on empty keep turning up
        repeat (100) send_request(pick_mode(50), pick_word(), pick_gap(), 1'b0, '0);

        // Fill until full; at least one pointer wraps on the way
        while (shadow_count < OCC_W'(DEPTH))
            send_request(pick_mode(95), pick_word(), pick_gap(), 1'b0, '0);

        // Hover at full so pushes get dropped at both ends
        repeat (60) send_request(pick_mode(65), pick_word(), pick_gap(), 1'b0, '0);

        // Drain from mixed ends
        repeat (250) send_request(pick_mode(10), pick_word(), pick_gap(), 1'b0, '0);

        start <= 1'b0;
        while (due_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d requests sent, occupancy peaked at %0d of %0d", sent_requests,
                 peak_count, DEPTH);
        $display("%0d pushes dropped on full, %0d pops on empty, %0d field errors",
                 full_drops, empty_pops, errors);
        if (errors == 0) begin
            $display("ring_buffer_deque: match");
        end else begin
            $display("ring_buffer_deque: mismatch");
        end
        $finish;
    end

    // Watchdog: stop a hung run well past the slowest legal one.
    initial begin
        #2_000_000;
        $display("timeout with %0d responses outstanding", due_responses.size());
        $display("ring_buffer_deque: mismatch");
        $finish;
    end

endmodule
